@@ hw/rtl/assert_macros.svh @@
// assertion helpers, clocked on clk and held off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition never seen at a clock edge out of reset
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ hw/rtl/ple_pkg.sv @@
`default_nettype none

package ple_pkg;

    localparam int unsigned CAPACITY_DEFAULT = 64;

    // payload widths
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned POS_W    = 7;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned FPOS_W   = 6;
    localparam int unsigned LEN_W    = 7;

    // request modes
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_FIND   = 2'd3;

    // result status
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] read_value;
        logic [FPOS_W-1:0]        found_position;
        logic [LEN_W-1:0]         list_length;
    } rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/ple_req_if.sv @@
`default_nettype none

interface ple_req_if;
    logic          valid;
    logic          ready;
    ple_pkg::req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ple_rsp_if.sv @@
`default_nettype none

interface ple_rsp_if;
    logic          valid;
    logic          ready;
    ple_pkg::rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ple_store.sv @@
`default_nettype none

// entry memory: one write port, one read port with registered data
module ple_store #(
    parameter int unsigned DEPTH  = ple_pkg::CAPACITY_DEFAULT,
    parameter int unsigned DATA_W = ple_pkg::DATA_W,
    parameter type         cmd_t  = logic
) (
    input  wire logic              clk,
    input  wire cmd_t              cmd,
    output logic [DATA_W-1:0]      rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr] <= cmd.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data <= mem[cmd.rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/positional_list_engine_top.sv @@
`default_nettype none

// channel   dir   modport   payload          transfer
// req       in    sink      ple_pkg::req_t   valid & ready at posedge clk
// rsp       out   source    ple_pkg::rsp_t   valid & ready at posedge clk
//
// one request at a time; the entry memory has one read and one write port,
// so every shift or compare step is a read, then a write or compare
// rst_n clears the length and the control; the entry memory is never cleared
// a finished result sits in the rsp register; the next request may be taken
// while it waits, and the sequencer holds in its done step if it is still full

`include "assert_macros.svh"

module positional_list_engine_top #(
    parameter int unsigned CAPACITY = ple_pkg::CAPACITY_DEFAULT
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ple_req_if.sink     req,
    ple_rsp_if.source   rsp
);

    localparam int unsigned ADDR_W = $clog2(CAPACITY);
    localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
    localparam int unsigned DATA_W = ple_pkg::DATA_W;
    // compare width: holds any position or length plus one
    localparam int unsigned CMP_W  =
        ((CNT_W > ple_pkg::POS_W) ? CNT_W : ple_pkg::POS_W) + 1;

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_INS_RD   = 4'd1;
    localparam logic [3:0] S_INS_WR   = 4'd2;
    localparam logic [3:0] S_INS_PUT  = 4'd3;
    localparam logic [3:0] S_DEL_RD   = 4'd4;
    localparam logic [3:0] S_DEL_WR   = 4'd5;
    localparam logic [3:0] S_RD_WAIT  = 4'd6;
    localparam logic [3:0] S_FIND_RD  = 4'd7;
    localparam logic [3:0] S_FIND_CMP = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_cmd_t;

    // control state
    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;

    // working registers of the current request
    logic [CNT_W-1:0]             idx_reg, idx_next;
    logic [CNT_W-1:0]             pos_reg, pos_next;
    logic [DATA_W-1:0]            val_reg, val_next;
    logic [ple_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [DATA_W-1:0]            rdval_reg, rdval_next;
    logic [CNT_W-1:0]             fpos_reg, fpos_next;
    ple_pkg::rsp_t                out_reg, out_next;

    mem_cmd_t          mem_cmd;
    logic [DATA_W-1:0] mem_rd_data;

    // helpers
    logic [CMP_W-1:0] req_pos_c;
    logic [CMP_W-1:0] cnt_c;
    logic [CMP_W-1:0] pos_c;
    logic [CNT_W-1:0] idx_inc;
    logic [CNT_W-1:0] idx_dec;
    logic             out_free;

    assign req_pos_c = CMP_W'(req.payload.position);
    assign cnt_c     = CMP_W'(count_reg);
    assign pos_c     = CMP_W'(pos_reg);
    assign idx_inc   = idx_reg + CNT_W'(1);
    assign idx_dec   = idx_reg - CNT_W'(1);
    assign out_free  = !out_valid_reg || rsp.ready;

    ple_store #(
        .DEPTH  (CAPACITY),
        .DATA_W (DATA_W),
        .cmd_t  (mem_cmd_t)
    ) u_store (
        .clk     (clk),
        .cmd     (mem_cmd),
        .rd_data (mem_rd_data)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.payload = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        status_next    = status_reg;
        rdval_next     = rdval_reg;
        fpos_next      = fpos_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp.ready;

        mem_cmd.wr_en   = 1'b0;
        mem_cmd.wr_addr = idx_reg[ADDR_W-1:0];
        mem_cmd.wr_data = mem_rd_data;
        mem_cmd.rd_en   = 1'b0;
        mem_cmd.rd_addr = idx_reg[ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    val_next    = req.payload.value;
                    pos_next    = CNT_W'(req.payload.position);
                    idx_next    = CNT_W'(req.payload.position);
                    status_next = ple_pkg::ST_OK;
                    rdval_next  = '0;
                    fpos_next   = '0;
                    state_next  = S_DONE;
                    unique case (req.payload.mode)
                        ple_pkg::MODE_INSERT:
                        begin
                            if (req_pos_c > cnt_c)
                            begin
                                status_next = ple_pkg::ST_RANGE;
                            end
                            else if (cnt_c >= CMP_W'(CAPACITY))
                            begin
                                status_next = ple_pkg::ST_FULL;
                            end
                            else if (cnt_c > req_pos_c)
                            begin
                                // open a gap: move entries up from the tail
                                idx_next   = count_reg;
                                state_next = S_INS_RD;
                            end
                            else
                            begin
                                state_next = S_INS_PUT;
                            end
                        end
                        ple_pkg::MODE_DELETE:
                        begin
                            if (req_pos_c >= cnt_c)
                            begin
                                status_next = ple_pkg::ST_RANGE;
                            end
                            else if (req_pos_c + CMP_W'(1) < cnt_c)
                            begin
                                state_next = S_DEL_RD;
                            end
                            else
                            begin
                                // tail entry: nothing to move
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        ple_pkg::MODE_READ:
                        begin
                            if (req_pos_c >= cnt_c)
                            begin
                                status_next = ple_pkg::ST_RANGE;
                            end
                            else
                            begin
                                mem_cmd.rd_en   = 1'b1;
                                mem_cmd.rd_addr = req.payload.position[ADDR_W-1:0];
                                state_next      = S_RD_WAIT;
                            end
                        end
                        ple_pkg::MODE_FIND:
                        begin
                            idx_next = '0;
                            if (count_reg == '0)
                            begin
                                status_next = ple_pkg::ST_NOT_FOUND;
                            end
                            else
                            begin
                                state_next = S_FIND_RD;
                            end
                        end
                    endcase
                end
            end
            S_INS_RD:
            begin
                mem_cmd.rd_en   = 1'b1;
                mem_cmd.rd_addr = idx_dec[ADDR_W-1:0];
                state_next      = S_INS_WR;
            end
            S_INS_WR:
            begin
                mem_cmd.wr_en = 1'b1;
                idx_next      = idx_dec;
                if (CMP_W'(idx_dec) > pos_c)
                begin
                    state_next = S_INS_RD;
                end
                else
                begin
                    state_next = S_INS_PUT;
                end
            end
            S_INS_PUT:
            begin
                mem_cmd.wr_en   = 1'b1;
                mem_cmd.wr_addr = pos_reg[ADDR_W-1:0];
                mem_cmd.wr_data = val_reg;
                count_next      = count_reg + CNT_W'(1);
                state_next      = S_DONE;
            end
            S_DEL_RD:
            begin
                mem_cmd.rd_en   = 1'b1;
                mem_cmd.rd_addr = idx_inc[ADDR_W-1:0];
                state_next      = S_DEL_WR;
            end
            S_DEL_WR:
            begin
                mem_cmd.wr_en = 1'b1;
                idx_next      = idx_inc;
                if (CMP_W'(idx_inc) + CMP_W'(1) < cnt_c)
                begin
                    state_next = S_DEL_RD;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
            end
            S_RD_WAIT:
            begin
                rdval_next = mem_rd_data;
                state_next = S_DONE;
            end
            S_FIND_RD:
            begin
                mem_cmd.rd_en = 1'b1;
                state_next    = S_FIND_CMP;
            end
            S_FIND_CMP:
            begin
                if (mem_rd_data == val_reg)
                begin
                    fpos_next  = idx_reg;
                    state_next = S_DONE;
                end
                else if (CMP_W'(idx_inc) < cnt_c)
                begin
                    idx_next   = idx_inc;
                    state_next = S_FIND_RD;
                end
                else
                begin
                    status_next = ple_pkg::ST_NOT_FOUND;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                // hand the result to the output register once it is free
                if (out_free)
                begin
                    out_next.status         = status_reg;
                    out_next.read_value     = $signed(rdval_reg);
                    out_next.found_position = ple_pkg::FPOS_W'(fpos_reg);
                    out_next.list_length    = ple_pkg::LEN_W'(count_reg);
                    out_valid_next          = 1'b1;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        rdval_reg  <= rdval_next;
        fpos_reg   <= fpos_next;
        out_reg    <= out_next;
    end

    // length changes only when an insert lands or a delete finishes
    `ASSERT_CLK(a_count_change,
        !$stable(count_reg) |-> ($past(state_reg) == S_INS_PUT
            || $past(state_reg) == S_DEL_WR || $past(state_reg) == S_IDLE),
        "list length changed outside insert or delete")
    // length stays within capacity
    `ASSERT_CLK(a_count_bound, CNT_W'(CAPACITY) >= count_reg,
        "list length above capacity")
    // read and find never write the entry memory
    `ASSERT_NEVER(a_no_write_on_lookup,
        mem_cmd.wr_en && (state_reg == S_RD_WAIT || state_reg == S_FIND_RD
            || state_reg == S_FIND_CMP),
        "entry memory written during lookup")
    // a new result only comes out of the done step
    `ASSERT_CLK(a_result_from_done, $rose(out_valid_reg) |-> $past(state_reg) == S_DONE,
        "result raised outside done step")

endmodule

`default_nettype wire
